// ===== hw/rtl/ida_pkg.sv =====
// Shared types, constants and the GF(2^8) multiply for the share encoder.
package ida_pkg;

  // Register indexes on the configuration port
  localparam logic [3:0] RegShareCount  = 4'd0;
  localparam logic [3:0] RegDataPerGroup = 4'd1;

  // Register reset values
  localparam logic [4:0] ShareCountRst   = 5'd16;
  localparam logic [4:0] DataPerGroupRst = 5'd1;

  // Share slots the encoder can ever hold, and the group size ceiling
  localparam int unsigned SlotsMax = 16;
  localparam logic [4:0]  GroupMax = 5'd16;

  // Slots updated per cycle in the back end
  localparam int unsigned Lanes = 4;

  // Entries in the queue between front and back end
  localparam int unsigned QueueDepth = 2;

  // GF(2^8) reduction constant (polynomial 0x11B) and byte mask
  localparam logic [7:0] GfReduce = 8'h1B;
  localparam logic [7:0] ByteMask = 8'hFF;

  // One classified data word on its way to the back end
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       close;      // this word completes its group
  } ida_item_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [4:0] group_size;   // m, 1..16
    logic [4:0] share_count;  // n, 1..slots
  } ida_cfg_t;

  // Shift-and-add multiply in GF(2^8)
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = '0;
    x   = a & ByteMask;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = x[7] ? ((x << 1) ^ GfReduce) : (x << 1);
    end
    return acc;
  endfunction

endpackage

// ===== hw/rtl/ida_ifs.sv =====
// Channel interfaces: data input, share output and configuration writes.
interface ida_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ida_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] share_index;
  logic [7:0] share_byte;
  logic       group_end;
  logic       stream_end;

  modport source (output valid, share_index, share_byte, group_end, stream_end,
                  input ready);
  modport sink   (input valid, share_index, share_byte, group_end, stream_end,
                  output ready);
endinterface

interface ida_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] reg_index;
  logic [7:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== hw/rtl/ida_front.sv =====
// Front end: accepts data words and marks the one that closes each group.
module ida_front import ida_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ida_cfg_t  cfg_i,
  input  logic      in_valid_i,
  input  logic [7:0] in_data_byte_i,
  input  logic      in_last_byte_i,
  output logic      in_ready_o,
  output logic      push_valid_o,
  output ida_item_t push_item_o,
  input  logic      push_ready_i
);

  logic [3:0] pos_q, pos_d;
  logic [4:0] taken;
  logic       close;

  // Group position tracking
  always_comb begin
    taken = {1'b0, pos_q} + 5'd1;
    close = in_last_byte_i || (taken >= cfg_i.group_size);
    pos_d = close ? 4'd0 : taken[3:0];
  end

  assign in_ready_o             = push_ready_i;
  assign push_valid_o           = in_valid_i;
  assign push_item_o.data_byte  = in_data_byte_i;
  assign push_item_o.last_byte  = in_last_byte_i;
  assign push_item_o.close      = close;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_valid_i && push_ready_i) begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== hw/rtl/ida_queue.sv =====
// Short queue of classified words between front and back end.
module ida_queue import ida_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  input  ida_item_t push_item_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output ida_item_t pop_item_o,
  input  logic      pop_ready_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  ida_item_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hw/rtl/ida_back.sv =====
// Back end: folds each word into the share sums, then emits the shares when a word closes its group.
module ida_back import ida_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ida_cfg_t   cfg_i,
  input  logic       pop_valid_i,
  input  ida_item_t  pop_item_i,
  output logic       pop_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] out_share_index_o,
  output logic [7:0] out_share_byte_o,
  output logic       out_group_end_o,
  output logic       out_stream_end_o
);

  // Slots rounded up to whole lane groups; one rotation by Lanes per cycle
  localparam int unsigned PadSlots = ((NUM_SLOTS + Lanes - 1) / Lanes) * Lanes;
  localparam int unsigned Steps    = PadSlots / Lanes;
  localparam int unsigned StepW    = (Steps > 1) ? $clog2(Steps) : 1;
  localparam int unsigned SlotW    = $clog2(PadSlots);

  typedef enum logic [1:0] {
    StIdle,
    StUpdate,
    StEmit
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;
  ida_item_t        cur_q;
  logic [3:0]       idx_q;
  logic [7:0]       acc_q [PadSlots];
  logic [7:0]       pow_q [PadSlots];
  logic [7:0]       acc_d [PadSlots];
  logic [7:0]       pow_d [PadSlots];
  logic [7:0]       lane_acc [Lanes];
  logic [7:0]       lane_pow [Lanes];
  logic [7:0]       slot_id [Lanes];
  logic             out_valid_q;
  logic [3:0]       out_index_q;
  logic [7:0]       out_byte_q;
  logic             out_gend_q;
  logic             out_send_q;
  logic             last_share;
  logic             emit_fire;

  assign pop_ready_o       = (state_q == StIdle);
  assign out_valid_o       = out_valid_q;
  assign out_share_index_o = out_index_q;
  assign out_share_byte_o  = out_byte_q;
  assign out_group_end_o   = out_gend_q;
  assign out_stream_end_o  = out_send_q;
  assign last_share        = ({1'b0, idx_q} + 5'd1 == cfg_i.share_count);
  // Output register takes a new share word this cycle
  assign emit_fire         = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  // Lane arithmetic on the head slots, then rotate the slot ring by Lanes
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      slot_id[k]  = 8'(int'(step_q) * Lanes + k);
      lane_acc[k] = acc_q[k] ^ gf_mul(pow_q[k], cur_q.data_byte);
      lane_pow[k] = gf_mul(pow_q[k], slot_id[k]);
    end
    for (int e = 0; e < PadSlots; e++) begin
      if (e < PadSlots - Lanes) begin
        acc_d[e] = acc_q[(e + Lanes) % PadSlots];
        pow_d[e] = pow_q[(e + Lanes) % PadSlots];
      end else begin
        acc_d[e] = lane_acc[e % Lanes];
        pow_d[e] = lane_pow[e % Lanes];
      end
    end
  end

  // Sequencer, share state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int e = 0; e < PadSlots; e++) begin
        acc_q[e] <= 8'h00;
        pow_q[e] <= 8'h01;
      end
    end else begin
      if (out_valid_q && out_ready_i && !emit_fire) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (pop_valid_i) begin
            cur_q   <= pop_item_i;
            step_q  <= '0;
            state_q <= StUpdate;
          end
        end
        StUpdate: begin
          for (int e = 0; e < PadSlots; e++) begin
            acc_q[e] <= acc_d[e];
            pow_q[e] <= pow_d[e];
          end
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(Steps - 1)) begin
            idx_q   <= '0;
            state_q <= cur_q.close ? StEmit : StIdle;
          end
        end
        StEmit: begin
          if (emit_fire) begin
            out_valid_q <= 1'b1;
            out_index_q <= idx_q;
            out_byte_q  <= acc_q[idx_q[SlotW-1:0]];
            out_gend_q  <= last_share;
            out_send_q  <= last_share && cur_q.last_byte;
            idx_q       <= idx_q + 4'd1;
            if (last_share) begin
              for (int e = 0; e < PadSlots; e++) begin
                acc_q[e] <= 8'h00;
                pow_q[e] <= 8'h01;
              end
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ida_share_encoder.sv =====
// Top level of the GF(2^8) information dispersal share encoder.
//
//  channel  dir  word                                            handshake
//  in_ch    in   data_byte[7:0], last_byte                       valid/ready
//  out_ch   out  share_index[3:0], share_byte[7:0], group_end,   valid/ready
//                stream_end
//  cfg_ch   in   reg_index[3:0], wdata[7:0] (0 share_count,      valid/ready
//                1 data_per_group, others ignored)
//
// Each data word is folded in by the back end in update steps that rotate the
// slot ring (four share slots updated per cycle by four GF multiply lanes),
// after the idle state takes it from the queue; a closing word then emits
// its n shares one by one, paced by the output register.
// A two-word queue lets the front take words while the back end is busy.
// Reset is asynchronous, active low; it clears all sums, powers to one and
// the registers to share_count 16, data_per_group 1. No clearing pass.
module ida_share_encoder import ida_pkg::*; #(
  parameter int unsigned MAX_SHARES = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ida_in_if.sink     in_ch,
  ida_out_if.source  out_ch,
  ida_cfg_if.sink    cfg_ch
);

  localparam int unsigned NumSlots = (MAX_SHARES < SlotsMax) ? MAX_SHARES : SlotsMax;

  logic [4:0] share_count_q;
  logic [4:0] data_per_group_q;
  ida_cfg_t   cfg_eff;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  ida_item_t  push_item, pop_item;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      share_count_q    <= ShareCountRst;
      data_per_group_q <= DataPerGroupRst;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.reg_index == RegShareCount) begin
        share_count_q <= cfg_ch.wdata[4:0];
      end else if (cfg_ch.reg_index == RegDataPerGroup) begin
        data_per_group_q <= cfg_ch.wdata[4:0];
      end
    end
  end

  // Clamp to the supported ranges
  always_comb begin
    if (data_per_group_q == 5'd0) cfg_eff.group_size = 5'd1;
    else if (data_per_group_q > GroupMax) cfg_eff.group_size = GroupMax;
    else cfg_eff.group_size = data_per_group_q;
    if (share_count_q == 5'd0) cfg_eff.share_count = 5'd1;
    else if (share_count_q > 5'(NumSlots)) cfg_eff.share_count = 5'(NumSlots);
    else cfg_eff.share_count = share_count_q;
  end

  ida_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_eff),
    .in_valid_i     (in_ch.valid),
    .in_data_byte_i (in_ch.data_byte),
    .in_last_byte_i (in_ch.last_byte),
    .in_ready_o     (in_ch.ready),
    .push_valid_o   (push_valid),
    .push_item_o    (push_item),
    .push_ready_i   (push_ready)
  );

  ida_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  ida_back #(
    .NUM_SLOTS (NumSlots)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_eff),
    .pop_valid_i       (pop_valid),
    .pop_item_i        (pop_item),
    .pop_ready_o       (pop_ready),
    .out_valid_o       (out_ch.valid),
    .out_ready_i       (out_ch.ready),
    .out_share_index_o (out_ch.share_index),
    .out_share_byte_o  (out_ch.share_byte),
    .out_group_end_o   (out_ch.group_end),
    .out_stream_end_o  (out_ch.stream_end)
  );

`ifndef NO_ASSERTIONS
  // Shown share index stays below the effective share count
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> ({1'b0, out_ch.share_index} < cfg_eff.share_count))
    else $error("share index beyond share count");

  // A stream end only ever closes a group
  a_stream_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.stream_end) |-> out_ch.group_end)
    else $error("stream end without group end");

  // Within a run, the word after a taken one carries the next share index
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.ready && !out_ch.group_end) |=>
      (!out_ch.valid || out_ch.share_index == $past(out_ch.share_index) + 4'd1))
    else $error("share index skipped");

  // Last share of a run always has the index n-1
  a_group_end_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.group_end) |->
      ({1'b0, out_ch.share_index} + 5'd1 == cfg_eff.share_count))
    else $error("group end on wrong share");
`endif

endmodule
